// ----- rtl/core/hkt_pkg.sv -----
// Shared types and constants of the hotkey tap detector.
`timescale 1ns / 1ps
`default_nettype none

package hkt_pkg;

	typedef enum logic [1:0] {
		OP_KEY_DOWN = 2'd0,
		OP_KEY_UP   = 2'd1,
		OP_TICK     = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_ENABLE   = 2'd0,
		CFG_MAIN_KEY = 2'd1,
		CFG_DELAY_MS = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_index_t;

	localparam logic [7:0]  CAPS_LOCK_CODE = 8'd20;
	localparam logic        ENABLE_RESET   = 1'b1;
	localparam logic [7:0]  MAIN_KEY_RESET = 8'd20;
	localparam logic [15:0] DELAY_RESET    = 16'd300;
	localparam int          SINCE_W        = 17;
	localparam logic [SINCE_W-1:0] SINCE_MAX = '1;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] key_code;
	} item_t;

	typedef struct packed {
		logic switch_layout;
		logic swallow;
	} result_t;

	typedef struct packed {
		logic        enable;
		logic [7:0]  main_key;
		logic [15:0] delay_ms;
	} cfg_t;

	// Update request from the front stage to the held-key bitmap.
	typedef struct packed {
		logic       press;
		logic       release_key;
		logic [7:0] code;
	} key_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/hotkey_tap_detector.sv -----
// Top level of the hotkey tap detector: request registers, configuration, result register.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Requests (key down, key up, one-millisecond tick) enter on item with
// item_valid; a request is taken at a clock edge where item_valid is high and
// item_stall is low. Each request yields exactly one result on result, with
// result_valid, taken when result_valid is high and result_stall is low.
// A request passes from the input register to the result register. One
// request per cycle is sustained while result_stall is low: the input
// register feeds the flag and timer logic, which updates its state and loads
// the result register at the same edge. When the receiver stalls, the held
// result stays put and one more request can still be taken into the input
// register; item_stall rises only when both registers are full. The held-key
// bitmap is a row of flip-flops with a running count, so a chord test costs one compare.
// Configuration writes use cfg_valid/cfg_ready (always ready) with cfg_index
// 0 enable, 1 main_key, 2 delay_ms; other indexes are ignored. Write only
// while the block is idle. Reset clears all keys, flags and timers, and
// restores enable=1, main_key=20, delay_ms=300.

module hotkey_tap_detector #(
	parameter int NUM_KEYS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire hkt_pkg::item_t    item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output hkt_pkg::result_t       result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data
);

	hkt_pkg::cfg_t     cfg_q;
	hkt_pkg::item_t    item_s1;
	logic              valid_s1;
	logic              out_free;
	logic              advance;
	logic              step;
	logic              other_held;
	hkt_pkg::key_cmd_t cmd;
	hkt_pkg::result_t  result_n;

	assign cfg_ready  = 1'b1;
	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign step       = advance && cfg_q.enable;

	assign cmd.press       = step && (hkt_pkg::op_t'(item_s1.operation) == hkt_pkg::OP_KEY_DOWN);
	assign cmd.release_key = step && (hkt_pkg::op_t'(item_s1.operation) == hkt_pkg::OP_KEY_UP);
	assign cmd.code        = item_s1.key_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= hkt_pkg::ENABLE_RESET;
			cfg_q.main_key <= hkt_pkg::MAIN_KEY_RESET;
			cfg_q.delay_ms <= hkt_pkg::DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (hkt_pkg::cfg_index_t'(cfg_index))
				hkt_pkg::CFG_ENABLE:   cfg_q.enable   <= cfg_data[0];
				hkt_pkg::CFG_MAIN_KEY: cfg_q.main_key <= cfg_data[7:0];
				hkt_pkg::CFG_DELAY_MS: cfg_q.delay_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (out_free) begin
				result_valid <= advance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			result <= result_n;
		end
	end

	hkt_key_tracker #(
		.NUM_KEYS(NUM_KEYS)
	) u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.other_held(other_held)
	);

	hkt_tap_logic u_tap (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg_q),
		.other_held(other_held),
		.result    (result_n)
	);

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled with room in the pipeline");
	a_advance_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("processed request produced no result");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/hkt_key_tracker.sv -----
// Bitmap of held keys with a running count of held keys.
`timescale 1ns / 1ps
`default_nettype none

module hkt_key_tracker #(
	parameter int NUM_KEYS = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hkt_pkg::key_cmd_t cmd,
	output logic                  other_held
);

	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int CNT_W = $clog2(NUM_KEYS + 1);

	logic [NUM_KEYS-1:0] held_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx;
	logic                in_range;
	logic                own;

	assign in_range = {1'b0, cmd.code} < 9'(NUM_KEYS);
	assign idx      = cmd.code[IDX_W-1:0];
	assign own      = in_range && held_q[idx];

	// Every held key other than the one in the request is counted.
	assign other_held = count_q != CNT_W'(own);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			count_q <= '0;
		end else if (in_range) begin
			if (cmd.press && !own) begin
				held_q[idx] <= 1'b1;
				count_q     <= count_q + CNT_W'(1);
			end else if (cmd.release_key && own) begin
				held_q[idx] <= 1'b0;
				count_q     <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(held_q)) == count_q)
		else $error("held key count out of step with bitmap");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/hkt_tap_logic.sv -----
// Trigger flags, hold and pair timers, and the tap decision for one request.
`timescale 1ns / 1ps
`default_nettype none

module hkt_tap_logic (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire hkt_pkg::item_t  item,
	input  wire hkt_pkg::cfg_t   cfg,
	input  wire logic            other_held,
	output hkt_pkg::result_t     result
);

	logic        trigger_q, long_q, waiting_q, blocked_q;
	logic [15:0] hold_q, pair_q;
	logic [hkt_pkg::SINCE_W-1:0] since_q;

	logic        trigger_n, long_n, waiting_n, blocked_n;
	logic [15:0] hold_n, pair_n;
	logic [hkt_pkg::SINCE_W-1:0] since_n;
	logic [15:0] start_val;
	logic        is_caps;
	logic        hit;

	assign start_val = (cfg.delay_ms == 16'd0) ? 16'd1 : cfg.delay_ms;
	assign is_caps   = cfg.main_key == hkt_pkg::CAPS_LOCK_CODE;
	assign hit       = item.key_code == cfg.main_key;

	always_comb begin
		trigger_n = trigger_q;
		long_n    = long_q;
		waiting_n = waiting_q;
		blocked_n = blocked_q;
		hold_n    = hold_q;
		pair_n    = pair_q;
		since_n   = since_q;
		result    = '0;
		if (step) begin
			case (hkt_pkg::op_t'(item.operation))
				hkt_pkg::OP_TICK: begin
					if (since_q != hkt_pkg::SINCE_MAX) begin
						since_n = since_q + hkt_pkg::SINCE_W'(1);
					end
					// The hold timer is handled first when both run out together.
					if (hold_q != 16'd0) begin
						hold_n = hold_q - 16'd1;
						if (hold_q == 16'd1) begin
							long_n    = 1'b1;
							waiting_n = 1'b0;
						end
					end
					if (pair_q != 16'd0) begin
						pair_n = pair_q - 16'd1;
						if (pair_q == 16'd1) begin
							result.switch_layout = waiting_n && !long_n && !blocked_n;
							waiting_n = 1'b0;
							blocked_n = 1'b0;
						end
					end
				end
				hkt_pkg::OP_KEY_DOWN: begin
					if (hit) begin
						if (other_held) begin
							trigger_n = 1'b0;
							waiting_n = 1'b0;
							long_n    = 1'b0;
							blocked_n = 1'b0;
							hold_n    = 16'd0;
							pair_n    = 16'd0;
						end else if (since_q <= {1'b0, cfg.delay_ms}) begin
							// A press inside the window of the last one is a repeat.
							blocked_n = 1'b1;
							waiting_n = 1'b0;
							long_n    = 1'b0;
							hold_n    = 16'd0;
							pair_n    = 16'd0;
							trigger_n = 1'b0;
							since_n   = '0;
						end else begin
							trigger_n = 1'b1;
							long_n    = 1'b0;
							blocked_n = 1'b0;
							waiting_n = 1'b0;
							hold_n    = start_val;
							pair_n    = start_val;
							since_n   = '0;
							result.swallow = is_caps;
						end
					end else if (trigger_q) begin
						trigger_n = 1'b0;
						waiting_n = 1'b0;
						long_n    = 1'b0;
						blocked_n = 1'b0;
						hold_n    = 16'd0;
						pair_n    = 16'd0;
					end
				end
				hkt_pkg::OP_KEY_UP: begin
					if (hit && trigger_q) begin
						hold_n    = 16'd0;
						trigger_n = 1'b0;
						if (long_q) begin
							waiting_n = 1'b0;
							blocked_n = 1'b0;
						end else if (pair_q == 16'd0) begin
							result.switch_layout = !blocked_q;
							waiting_n = 1'b0;
							blocked_n = 1'b0;
							result.swallow = is_caps;
						end else begin
							// Released early: the switch fires when the pair timer ends.
							waiting_n = 1'b1;
							result.swallow = is_caps;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= 1'b0;
			long_q    <= 1'b0;
			waiting_q <= 1'b0;
			blocked_q <= 1'b0;
			hold_q    <= 16'd0;
			pair_q    <= 16'd0;
			since_q   <= hkt_pkg::SINCE_MAX;
		end else begin
			trigger_q <= trigger_n;
			long_q    <= long_n;
			waiting_q <= waiting_n;
			blocked_q <= blocked_n;
			hold_q    <= hold_n;
			pair_q    <= pair_n;
			since_q   <= since_n;
		end
	end

`ifndef SYNTHESIS
	a_hold_needs_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q != 16'd0) |-> trigger_q)
		else $error("hold timer running without a held trigger");
	a_hold_tracks_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_q != 16'd0) |-> (hold_q == pair_q))
		else $error("hold and pair timers diverged while holding");
`endif

endmodule

`default_nettype wire
